/* hdl/dfc_pkg.sv */
// ----------------------------------------------------------------------------
// dfc_pkg
// Shared types and constants for the direct-form FIR convolution block.
// ----------------------------------------------------------------------------
package dfc_pkg;

  // Transaction kinds carried on in_tuser.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // Fixed field widths of the interface.
  localparam int TAP_IDX_W = 6;
  localparam int TAP_CNT_W = 7;

  // Tap count after reset.
  localparam logic [TAP_CNT_W-1:0] TAP_CNT_RST = 7'd64;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clr;     // clear the accumulator
    logic mul_en;  // memory read data is valid, form the product
    logic acc_en;  // product is valid, add it to the accumulator
  } mac_ctl_t;

endpackage

/* hdl/dfc_tap_mem.sv */
// ----------------------------------------------------------------------------
// dfc_tap_mem
// Coefficient memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dfc_tap_mem #(
  parameter int DEPTH = 64,
  parameter int DW    = 16,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/dfc_delay_mem.sv */
// ----------------------------------------------------------------------------
// dfc_delay_mem
// Circular sample memory with one valid bit per entry. An entry that is not
// valid reads as zero, so reset and the end-of-sequence clear only reset the valid bits.
// ----------------------------------------------------------------------------
module dfc_delay_mem #(
  parameter int DEPTH = 64,
  parameter int DW    = 16,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic          wr_zero,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          clr_all,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DW-1:0]    rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr_all) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= !wr_zero;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !wr_zero) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

/* hdl/dfc_mac.sv */
// ----------------------------------------------------------------------------
// dfc_mac
// Shared multiply-accumulate unit with rounding and saturation of the sum.
// ----------------------------------------------------------------------------
module dfc_mac
  import dfc_pkg::*;
#(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  mac_ctl_t                      ctl,
  input  logic signed [SAMPLE_BITS-1:0] smp,
  input  logic signed [SAMPLE_BITS-1:0] coef,
  output logic signed [SAMPLE_BITS-1:0] y,
  output logic                          sat
);

  localparam int SB    = SAMPLE_BITS;
  localparam int FRAC  = SB - 1;
  localparam int PW    = 2 * SB;
  localparam int NAT_W = PW + $clog2(MAX_TAPS);
  localparam bit CLAMP = NAT_W > 63;
  localparam int ACC_W = CLAMP ? 64 : NAT_W;

  localparam logic signed [ACC_W:0] RND  = (ACC_W+1)'(64'sd1 <<< (FRAC - 1));
  localparam logic signed [ACC_W:0] SMAX = (ACC_W+1)'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [ACC_W:0] SMIN = (ACC_W+1)'(-(64'sd1 <<< (SB - 1)));

  logic signed [PW-1:0]    prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W:0]   sum;
  logic signed [ACC_W:0]   rsum;
  logic signed [ACC_W:0]   shifted;

  assign sum = (ACC_W+1)'(acc_r) + (ACC_W+1)'(prod_r);

  generate
    if (CLAMP) begin : g_clamp
      // Very wide samples: the running sum is held to +-2^62 after each step.
      localparam logic signed [ACC_W:0] LIM = (ACC_W+1)'(64'sd1 <<< 62);
      always_comb begin
        if (sum > LIM) begin
          acc_nxt = ACC_W'(LIM);
        end else if (sum < -LIM) begin
          acc_nxt = ACC_W'(-LIM);
        end else begin
          acc_nxt = ACC_W'(sum);
        end
      end
    end else begin : g_plain
      assign acc_nxt = ACC_W'(sum);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= smp * coef;
    end
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  // Round half up, floor shift, then clip to the sample range.
  assign rsum    = (ACC_W+1)'(acc_r) + RND;
  assign shifted = rsum >>> FRAC;

  always_comb begin
    if (shifted > SMAX) begin
      y   = SB'(SMAX);
      sat = 1'b1;
    end else if (shifted < SMIN) begin
      y   = SB'(SMIN);
      sat = 1'b1;
    end else begin
      y   = SB'(shifted);
      sat = 1'b0;
    end
  end

endmodule

/* hdl/direct_fir_convolution.sv */
// ----------------------------------------------------------------------------
// direct_fir_convolution
// Direct-form FIR convolution of a sample stream with a loaded impulse response.
// ----------------------------------------------------------------------------
// A sample transaction walks its taps in RUN and then waits in RND for the
// output register; a load transaction completes in its acceptance cycle.
// A new sample is not taken until the last one is through, as the single shared
// multiply-accumulate walks the delay and tap memories one tap per cycle;
// loads go at one per cycle. A held result register stalls the next result.
// A sample marked last yields one result per tap in use, each in turn.
// Reset clears control state, zeroes the delay line and sets tap_count to 64.
// ----------------------------------------------------------------------------
module direct_fir_convolution
  import dfc_pkg::*;
#(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,

  // Configuration: tap_count, written whenever cfg_we is high.
  input  logic                 cfg_we,
  input  logic [TAP_CNT_W-1:0] cfg_wdata,

  // Input channel.
  input  logic                                              in_tvalid,
  output logic                                              in_tready,
  // in_tdata: sample_value [SAMPLE_BITS-1:0], tap_index [SAMPLE_BITS+5:SAMPLE_BITS]
  input  logic [((SAMPLE_BITS + TAP_IDX_W + 7) / 8) * 8-1:0] in_tdata,
  // in_tuser: op (OP_SAMPLE or OP_LOAD)
  input  logic                                              in_tuser,
  // in_tlast: last_sample
  input  logic                                              in_tlast,

  // Result channel.
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // out_tdata: filtered_sample [SAMPLE_BITS-1:0]
  output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] out_tdata,
  // out_tuser: saturated
  output logic                                   out_tuser,
  // out_tlast: last_output
  output logic                                   out_tlast
);

  localparam int SB    = SAMPLE_BITS;
  localparam int OUT_W = ((SB + 7) / 8) * 8;
  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W = $clog2(MAX_TAPS + 2);

  typedef enum logic [1:0] {
    IDLE,  // waiting for a transaction
    RUN,   // walking the taps through the multiply-accumulate
    RND    // rounded result ready, waiting for the output register
  } state_t;

  // Accepted fields.
  logic signed [SB-1:0]   in_sample;
  logic [TAP_IDX_W-1:0]   in_tap_idx;
  assign in_sample  = in_tdata[SB-1:0];
  assign in_tap_idx = in_tdata[SB+TAP_IDX_W-1:SB];

  state_t               state_r;
  logic [TAP_CNT_W-1:0] tap_count_r;
  logic [AW-1:0]        head_r;     // delay-line slot of the newest sample
  logic [CNT_W-1:0]     cnt_r;      // tap walk counter within RUN
  logic [CNT_W-1:0]     k_r;        // results given for the current transaction
  logic [CNT_W-1:0]     t_r;        // taps in use, latched at acceptance
  logic                 last_r;     // current transaction flushes the tail
  logic                 v1_r;       // memory read data valid this cycle
  logic                 v2_r;       // product valid this cycle
  logic                 out_valid_r;
  logic [OUT_W-1:0]     out_data_r;
  logic                 out_sat_r;
  logic                 out_last_r;

  logic                  accept;
  logic                  issue;
  logic                  fin;
  logic                  can_load;
  logic [AW-1:0]         head_dec;
  logic [AW:0]           rd_sum;
  logic [AW-1:0]         dly_rd_addr;
  logic [AW-1:0]         walk_idx;
  logic [CNT_W-1:0]      taps_use;
  logic                  dly_we;
  logic                  dly_zero;
  logic                  dly_clr;
  logic                  tap_we;
  logic signed [SB-1:0]  dly_rd_data;
  logic signed [SB-1:0]  tap_rd_data;
  logic signed [SB-1:0]  mac_y;
  logic                  mac_sat;
  mac_ctl_t              mac_ctl;

  assign in_tready = (state_r == IDLE);
  assign accept    = in_tvalid && in_tready;

  // The configured count, with zero read as one and large values capped.
  always_comb begin
    if (tap_count_r == '0) begin
      taps_use = CNT_W'(1);
    end else if (tap_count_r > TAP_CNT_W'(MAX_TAPS)) begin
      taps_use = CNT_W'(MAX_TAPS);
    end else begin
      taps_use = CNT_W'(tap_count_r);
    end
  end

  // The delay line is a ring: a new sample goes one slot below the head, and
  // tap i lives at head + i modulo the depth.
  assign head_dec    = (head_r == '0) ? AW'(MAX_TAPS - 1) : head_r - AW'(1);
  assign walk_idx    = cnt_r[AW-1:0];
  assign rd_sum      = {1'b0, head_r} + {1'b0, walk_idx};
  assign dly_rd_addr = (rd_sum >= (AW+1)'(MAX_TAPS)) ? AW'(rd_sum - (AW+1)'(MAX_TAPS))
                                                      : rd_sum[AW-1:0];

  assign issue    = (state_r == RUN) && (cnt_r < t_r);
  assign fin      = !last_r || (k_r == t_r - CNT_W'(1));
  assign can_load = !out_valid_r || out_tready;

  // Memory writes happen only outside RUN, so a write never overlaps the
  // reads of the tap walk and no forwarding is needed.
  always_comb begin
    dly_we   = 1'b0;
    dly_zero = 1'b0;
    dly_clr  = 1'b0;
    tap_we   = 1'b0;
    case (state_r)
      IDLE: begin
        if (accept && in_tuser == OP_SAMPLE) begin
          dly_we = 1'b1;
        end
        if (accept && in_tuser == OP_LOAD &&
            {1'b0, in_tap_idx} < (TAP_IDX_W+1)'(MAX_TAPS)) begin
          tap_we = 1'b1;
        end
      end
      RND: begin
        if (can_load && fin) begin
          dly_clr = last_r;
        end else if (can_load) begin
          dly_we   = 1'b1;
          dly_zero = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign mac_ctl.clr    = (state_r == RUN) && (cnt_r == '0);
  assign mac_ctl.mul_en = v1_r;
  assign mac_ctl.acc_en = v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      tap_count_r <= TAP_CNT_RST;
      head_r      <= '0;
      cnt_r       <= '0;
      k_r         <= '0;
      t_r         <= '0;
      last_r      <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      out_sat_r   <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        tap_count_r <= cfg_wdata;
      end
      // A new result loads the register; otherwise an accepted one empties it.
      if (state_r == RND && can_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      v1_r <= issue;
      v2_r <= v1_r;
      case (state_r)
        IDLE: begin
          if (accept && in_tuser == OP_SAMPLE) begin
            head_r  <= head_dec;
            t_r     <= taps_use;
            last_r  <= in_tlast;
            k_r     <= '0;
            cnt_r   <= '0;
            state_r <= RUN;
          end
        end
        RUN: begin
          // The last product passes the memory read register and the product register before the accumulator takes it.
          if (cnt_r == t_r + CNT_W'(1)) begin
            state_r <= RND;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        RND: begin
          if (can_load) begin
            out_data_r  <= OUT_W'($unsigned(mac_y));
            out_sat_r   <= mac_sat;
            out_last_r  <= last_r && fin;
            if (fin) begin
              state_r <= IDLE;
            end else begin
              // Tail flush: shift a zero in and compute the next output.
              head_r  <= head_dec;
              k_r     <= k_r + CNT_W'(1);
              cnt_r   <= '0;
              state_r <= RUN;
            end
          end
        end
        default: begin
          state_r <= IDLE;
        end
      endcase
    end
  end

  dfc_delay_mem #(
    .DEPTH (MAX_TAPS),
    .DW    (SB),
    .AW    (AW)
  ) u_dly (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (dly_we),
    .wr_zero (dly_zero),
    .wr_addr (head_dec),
    .wr_data (in_sample),
    .clr_all (dly_clr),
    .rd_addr (dly_rd_addr),
    .rd_data (dly_rd_data)
  );

  dfc_tap_mem #(
    .DEPTH (MAX_TAPS),
    .DW    (SB),
    .AW    (AW)
  ) u_tap (
    .clk     (clk),
    .wr_en   (tap_we),
    .wr_addr (in_tap_idx[AW-1:0]),
    .wr_data (in_sample),
    .rd_addr (walk_idx),
    .rd_data (tap_rd_data)
  );

  dfc_mac #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SB)
  ) u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .smp  (dly_rd_data),
    .coef (tap_rd_data),
    .y    (mac_y),
    .sat  (mac_sat)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;
  assign out_tlast  = out_last_r;

  // The delay memory is never written while the tap walk reads it.
  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == RUN) |-> !dly_we && !dly_clr)
    else $error("delay memory written during tap walk");

  // Products only reach the accumulator while the walk is running.
  a_acc_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (state_r == RUN) && !mac_ctl.clr)
    else $error("accumulate outside tap walk");

  // A transaction never gives more results than the taps in use.
  a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != IDLE) |-> (k_r < t_r) && (t_r != '0))
    else $error("result count out of range");

  // A flagged final result comes only from a flushing transaction.
  a_last_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == RND && can_load && last_r == 1'b0) |=> !out_tlast)
    else $error("last flag on a plain sample result");

endmodule
